// ===== hw/rtl/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types, constants and calendar helpers for the day count to
// calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

  // Calendar constants
  localparam logic [11:0] EpochYear    = 12'd1978;
  localparam logic [6:0]  EpochYearTwo = 7'd78;
  localparam logic [6:0]  LastTwoDigit = 7'd99;
  localparam logic [3:0]  FirstMonth   = 4'd1;
  localparam logic [3:0]  LastMonth    = 4'd12;
  localparam logic [8:0]  LeapYearLen  = 9'd366;
  localparam logic [8:0]  PlainYearLen = 9'd365;

  // Sequencer state codes
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StYear  = 2'd1;
  localparam logic [1:0] StMonth = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  // One stamp handed to the core
  typedef struct packed {
    logic [15:0] day_count;
    logic [7:0]  hour_bcd;
    logic [7:0]  minute_bcd;
  } dcd_req_t;

  // One converted date from the core
  typedef struct packed {
    logic        stamp_valid;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [11:0] year_full;
    logic [6:0]  year_two_digit;
    logic [7:0]  hour_out;
    logic [7:0]  minute_out;
  } dcd_rsp_t;

  // Leap rule: every fourth year, no century exception
  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  // Days in a month, February stretched in leap years
  function automatic logic [8:0] month_len(input logic [3:0] month, input logic leap);
    logic [8:0] len;
    unique case (month)
      4'd2:                      len = leap ? 9'd29 : 9'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 9'd30;
      default:                   len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dcd_if.sv =====
// ----------------------------------------------------------------------------
// dcd_if
// Valid/ready channel interfaces for stamps in and dates out.
// ----------------------------------------------------------------------------
`default_nettype none

// Input stamp channel
interface dcd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] day_count;
  logic [7:0]  hour_bcd;
  logic [7:0]  minute_bcd;

  modport source (output valid, day_count, hour_bcd, minute_bcd, input ready);
  modport sink   (input valid, day_count, hour_bcd, minute_bcd, output ready);
endinterface

// Output date channel
interface dcd_out_if;
  logic        valid;
  logic        ready;
  logic        stamp_valid;
  logic [3:0]  month_number;
  logic [4:0]  day_of_month;
  logic [11:0] year_full;
  logic [6:0]  year_two_digit;
  logic [7:0]  hour_out;
  logic [7:0]  minute_out;

  modport source (output valid, stamp_valid, month_number, day_of_month, year_full,
                  year_two_digit, hour_out, minute_out, input ready);
  modport sink   (input valid, stamp_valid, month_number, day_of_month, year_full,
                  year_two_digit, hour_out, minute_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dcd_core.sv =====
// ----------------------------------------------------------------------------
// dcd_core
// Sequencer around one shared subtract/compare unit: strips whole years,
// then whole months, from the day count, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  input  wire dcd_pkg::dcd_req_t req_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  output dcd_pkg::dcd_rsp_t    rsp_o,
  input  wire logic            rsp_ready_i
);
  import dcd_pkg::*;

  logic [1:0]  state_q, state_d;
  logic        valid_q, valid_d;
  logic [15:0] n_q, n_d;
  logic [11:0] y_q, y_d;
  logic [6:0]  y2_q, y2_d;
  logic [3:0]  m_q, m_d;
  logic [7:0]  hr_q, hr_d;
  logic [7:0]  mn_q, mn_d;

  // Shared unit: length of current year or month, subtract and compare
  logic [8:0]  len;
  logic [16:0] diff;
  logic        gt;

  always_comb begin
    if (state_q == StYear) begin
      len = is_leap(y_q) ? LeapYearLen : PlainYearLen;
    end else begin
      len = month_len(m_q, is_leap(y_q));
    end
  end

  assign diff = {1'b0, n_q} - {8'd0, len};
  assign gt   = !diff[16] && (diff[15:0] != 16'd0);

  // Sequencer
  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    n_d     = n_q;
    y_d     = y_q;
    y2_d    = y2_q;
    m_d     = m_q;
    hr_d    = hr_q;
    mn_d    = mn_q;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          n_d     = req_i.day_count;
          y_d     = EpochYear;
          y2_d    = EpochYearTwo;
          m_d     = FirstMonth;
          hr_d    = req_i.hour_bcd;
          mn_d    = req_i.minute_bcd;
          valid_d = (req_i.day_count != 16'd0);
          state_d = (req_i.day_count != 16'd0) ? StYear : StDone;
        end
      end
      StYear: begin
        if (gt) begin
          n_d  = diff[15:0];
          y_d  = y_q + 12'd1;
          y2_d = (y2_q == LastTwoDigit) ? 7'd0 : y2_q + 7'd1;
        end else begin
          state_d = StMonth;
        end
      end
      StMonth: begin
        if ((m_q != LastMonth) && gt) begin
          n_d = diff[15:0];
          m_d = m_q + 4'd1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (rsp_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state under reset, payload free running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    y_q  <= y_d;
    y2_q <= y2_d;
    m_q  <= m_d;
    hr_q <= hr_d;
    mn_q <= mn_d;
  end

  // Result; a blank stamp reads as zero date fields
  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = (state_q == StDone);

  always_comb begin
    rsp_o.stamp_valid    = valid_q;
    rsp_o.month_number   = valid_q ? m_q : 4'd0;
    rsp_o.day_of_month   = valid_q ? n_q[4:0] : 5'd0;
    rsp_o.year_full      = valid_q ? y_q : 12'd0;
    rsp_o.year_two_digit = valid_q ? y2_q : 7'd0;
    rsp_o.hour_out       = hr_q;
    rsp_o.minute_out     = mn_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/day_count_to_calendar_date_top.sv =====
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_top
// Directory time stamp to calendar date converter, top level.
// ----------------------------------------------------------------------------
// Takes a 16-bit day count (day 1 = 1 Jan 1978, 0 = blank stamp) with BCD
// hour and minute bytes and returns month, day, four-digit year, year modulo
// 100 and the copied time bytes; leap years are every fourth year with no
// century rule. The single subtract/compare unit removes one year or one
// month per cycle. The input is not ready while a stamp converts; a finished
// date sits in an output register, so the next stamp can be taken while it
// waits.
`default_nettype none

module day_count_to_calendar_date_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dcd_in_if.sink     in_i,
  dcd_out_if.source  out_o
);
  import dcd_pkg::*;

  dcd_req_t req;
  dcd_rsp_t rsp;
  logic     rsp_valid;
  logic     rsp_ready;

  logic     out_valid_q;
  dcd_rsp_t out_q;

  assign req.day_count  = in_i.day_count;
  assign req.hour_bcd   = in_i.hour_bcd;
  assign req.minute_bcd = in_i.minute_bcd;

  dcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_i       (req),
    .req_ready_o (in_i.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_ready_i (rsp_ready)
  );

  // Output register: refill when empty or when the held date transfers
  assign rsp_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.stamp_valid    = out_q.stamp_valid;
  assign out_o.month_number   = out_q.month_number;
  assign out_o.day_of_month   = out_q.day_of_month;
  assign out_o.year_full      = out_q.year_full;
  assign out_o.year_two_digit = out_q.year_two_digit;
  assign out_o.hour_out       = out_q.hour_out;
  assign out_o.minute_out     = out_q.minute_out;

endmodule

`default_nettype wire

// ===== sim/tb_day_count_to_calendar_date_top.sv =====
// ----------------------------------------------------------------------------
// tb_day_count_to_calendar_date_top
// Self-checking bench for the day count to calendar date converter.
// ----------------------------------------------------------------------------
// A short table of directed stamps (blank stamps, first days, month and year
// edges, leap days, the 2100 leap year, the largest counts) is followed by
// random stamps. Every accepted stamp gets its expected date from the table
// where it is typed in, else from a local calendar model, and every date that
// leaves the block is compared field by field with the oldest expected one.
// Both channels idle at random, except over the last stretch of the run.
`timescale 1ns / 1ps

module tb_day_count_to_calendar_date_top;

  import dcd_pkg::*;

  localparam int unsigned RandomStamps  = 550;
  localparam int unsigned CalmTail      = 80;
  localparam int unsigned DirectedCount = 24;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 250;
  localparam int unsigned February      = 2;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // One stamp to send, with its date typed in where it is obvious
  typedef struct {
    dcd_req_t stamp;
    bit       typed;
    dcd_rsp_t want;
  } stamp_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic date_ready = 1'b0;
  logic calm_phase = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned error_count  = 0;

  stamp_row_t offered_stamps [$];
  dcd_rsp_t   expected_dates [$];

  dcd_in_if  stamp_ch ();
  dcd_out_if date_ch ();

  assign date_ch.ready = date_ready;

  day_count_to_calendar_date_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stamp_ch),
    .out_o  (date_ch)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Calendar model: strip whole years from the epoch, then whole months
  function automatic dcd_rsp_t convert_stamp(dcd_req_t stamp);
    int unsigned left;
    int unsigned ylen;
    int unsigned mlen;
    logic [11:0] yr;
    logic [3:0]  mo;
    dcd_rsp_t    date;
    date            = '0;
    date.hour_out   = stamp.hour_bcd;
    date.minute_out = stamp.minute_bcd;
    if (stamp.day_count == '0) return date;
    left = stamp.day_count;
    yr   = EpochYear;
    mo   = FirstMonth;
    while (1) begin
      ylen = (yr[1:0] == 2'b00) ? LeapYearLen : PlainYearLen;
      if (left <= ylen) break;
      left -= ylen;
      yr++;
    end
    while (mo < LastMonth) begin
      mlen = MonthDays[mo - 1];
      // leap February, no century exception
      if (mo == February && yr[1:0] == 2'b00) mlen++;
      if (left <= mlen) break;
      left -= mlen;
      mo++;
    end
    date.stamp_valid    = 1'b1;
    date.month_number   = mo;
    date.day_of_month   = left[4:0];
    date.year_full      = yr;
    date.year_two_digit = 7'(yr % 100);
    return date;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: date mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Present one stamp after an optional gap and hold it until its transfer
  task automatic present_stamp(stamp_row_t row, int unsigned gap);
    if (gap > 0) begin
      stamp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    stamp_ch.valid      <= 1'b1;
    stamp_ch.day_count  <= row.stamp.day_count;
    stamp_ch.hour_bcd   <= row.stamp.hour_bcd;
    stamp_ch.minute_bcd <= row.stamp.minute_bcd;
    offered_stamps.push_back(row);
    do @(posedge clk_i); while (stamp_ch.ready !== 1'b1);
  endtask

  function automatic int unsigned pick_gap();
    if (calm_phase || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  // Stimulus
  initial begin : stimulus
    stamp_row_t directed_rows [DirectedCount];
    stamp_row_t row;
    int unsigned pick;
    stamp_ch.valid      <= 1'b0;
    stamp_ch.day_count  <= '0;
    stamp_ch.hour_bcd   <= '0;
    stamp_ch.minute_bcd <= '0;
    directed_rows = '{
      // blank stamps keep the time bytes
      '{'{16'd0,     8'h00, 8'h00}, 1'b1, '{1'b0, 4'd0,  5'd0,  12'd0,    7'd0,  8'h00, 8'h00}},
      '{'{16'd0,     8'hFF, 8'hFF}, 1'b1, '{1'b0, 4'd0,  5'd0,  12'd0,    7'd0,  8'hFF, 8'hFF}},
      // first of January 1978 and early month edges
      '{'{16'd1,     8'h00, 8'h00}, 1'b1, '{1'b1, 4'd1,  5'd1,  12'd1978, 7'd78, 8'h00, 8'h00}},
      '{'{16'd1,     8'h23, 8'h59}, 1'b1, '{1'b1, 4'd1,  5'd1,  12'd1978, 7'd78, 8'h23, 8'h59}},
      '{'{16'd31,    8'h12, 8'h34}, 1'b1, '{1'b1, 4'd1,  5'd31, 12'd1978, 7'd78, 8'h12, 8'h34}},
      '{'{16'd32,    8'h00, 8'h01}, 1'b1, '{1'b1, 4'd2,  5'd1,  12'd1978, 7'd78, 8'h00, 8'h01}},
      '{'{16'd59,    8'h09, 8'h30}, 1'b1, '{1'b1, 4'd2,  5'd28, 12'd1978, 7'd78, 8'h09, 8'h30}},
      '{'{16'd60,    8'h10, 8'h00}, 1'b1, '{1'b1, 4'd3,  5'd1,  12'd1978, 7'd78, 8'h10, 8'h00}},
      '{'{16'd365,   8'h23, 8'h59}, 1'b1, '{1'b1, 4'd12, 5'd31, 12'd1978, 7'd78, 8'h23, 8'h59}},
      '{'{16'd366,   8'h00, 8'h00}, 1'b1, '{1'b1, 4'd1,  5'd1,  12'd1979, 7'd79, 8'h00, 8'h00}},
      // leap day 1980, end of 1980, turn of the century
      '{'{16'd790,   8'h12, 8'h00}, 1'b0, '0},
      '{'{16'd791,   8'h12, 8'h00}, 1'b0, '0},
      '{'{16'd1096,  8'hAA, 8'h55}, 1'b0, '0},
      '{'{16'd8036,  8'h55, 8'hAA}, 1'b0, '0},
      '{'{16'd8401,  8'h01, 8'h02}, 1'b0, '0},
      // around 2100, which counts as leap here
      '{'{16'd44560, 8'h3C, 8'hC3}, 1'b0, '0},
      '{'{16'd44620, 8'h99, 8'h99}, 1'b0, '0},
      '{'{16'd44621, 8'h0F, 8'hF0}, 1'b0, '0},
      // bit patterns and the largest counts
      '{'{16'h5555,  8'hA5, 8'h5A}, 1'b0, '0},
      '{'{16'hAAAA,  8'h5A, 8'hA5}, 1'b0, '0},
      '{'{16'h7FFF,  8'h80, 8'h7F}, 1'b0, '0},
      '{'{16'h8000,  8'h7F, 8'h80}, 1'b0, '0},
      '{'{16'd65534, 8'h00, 8'hFF}, 1'b0, '0},
      '{'{16'd65535, 8'hFF, 8'h00}, 1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) present_stamp(directed_rows[i], pick_gap());

    for (int unsigned n = 0; n < RandomStamps; n++) begin
      if (n == RandomStamps - CalmTail) calm_phase <= 1'b1;
      row.typed = 1'b0;
      row.want  = '0;
      pick      = $urandom_range(0, 15);
      // mostly full range, with blanks, early years and late years mixed in
      if (pick == 0)      row.stamp.day_count = '0;
      else if (pick < 5)  row.stamp.day_count = 16'($urandom_range(1, 2000));
      else if (pick < 7)  row.stamp.day_count = 16'($urandom_range(64000, 65535));
      else                row.stamp.day_count = 16'($urandom_range(0, 65535));
      row.stamp.hour_bcd   = 8'($urandom_range(0, 255));
      row.stamp.minute_bcd = 8'($urandom_range(0, 255));
      present_stamp(row, pick_gap());
    end
    stamp_ch.valid <= 1'b0;

    while (offered_stamps.size() != 0 || expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Input transfers: queue the expected date
  always @(posedge clk_i) begin : stamp_monitor
    stamp_row_t row;
    if (rst_ni && stamp_ch.valid && stamp_ch.ready === 1'b1) begin
      row = offered_stamps.pop_front();
      expected_dates.push_back(row.typed ? row.want : convert_stamp(row.stamp));
    end
  end

  // Output ready with random stall bursts
  always @(posedge clk_i) begin
    if (!calm_phase && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 13);
      date_ready <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      date_ready <= 1'b0;
    end else begin
      stall_left <= 0;
      date_ready <= 1'b1;
    end
  end

  // Output transfers: compare with the oldest expected date
  always @(posedge clk_i) begin : date_checker
    dcd_rsp_t want;
    if (rst_ni && date_ch.valid === 1'b1 && date_ready) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected date transfer", date_ch.day_of_month, 0);
      end else begin
        want = expected_dates.pop_front();
        compare_field("stamp_valid",    date_ch.stamp_valid,    want.stamp_valid);
        compare_field("month_number",   date_ch.month_number,   want.month_number);
        compare_field("day_of_month",   date_ch.day_of_month,   want.day_of_month);
        compare_field("year_full",      date_ch.year_full,      want.year_full);
        compare_field("year_two_digit", date_ch.year_two_digit, want.year_two_digit);
        compare_field("hour_out",       date_ch.hour_out,       want.hour_out);
        compare_field("minute_out",     date_ch.minute_out,     want.minute_out);
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if ((stamp_ch.valid && stamp_ch.ready === 1'b1) || (date_ch.valid === 1'b1 && date_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
